// ===== sv/ntr_pkg.sv =====
// ----------------------------------------------------------------------------
// ntr_pkg
// Shared types and constants for the retransmission tracker.
// ----------------------------------------------------------------------------
package ntr_pkg;

  localparam int unsigned MAX_SEQ = 65536;
  localparam int unsigned SEQ_W   = $clog2(MAX_SEQ);
  localparam int unsigned NBYTES  = MAX_SEQ / 8;
  localparam int unsigned BYTE_W  = $clog2(NBYTES);
  localparam int unsigned RING    = 64;
  localparam int unsigned RING_W  = $clog2(RING);
  localparam int unsigned TOT_W   = SEQ_W + 1;

  localparam logic [1:0] FN_RECORD = 2'd0;
  localparam logic [1:0] FN_FIN    = 2'd1;
  localparam logic [1:0] FN_NACK   = 2'd2;
  localparam logic [1:0] FN_POP    = 2'd3;

  localparam logic [3:0] ST_DONE     = 4'd0;
  localparam logic [3:0] ST_ACCEPTED = 4'd1;
  localparam logic [3:0] ST_STALE    = 4'd2;
  localparam logic [3:0] ST_RANGE    = 4'd3;
  localparam logic [3:0] ST_NEVER    = 4'd4;
  localparam logic [3:0] ST_PENDING  = 4'd5;
  localparam logic [3:0] ST_BADROUND = 4'd6;
  localparam logic [3:0] ST_POPPED   = 4'd7;
  localparam logic [3:0] ST_NONE     = 4'd8;

  typedef struct packed {
    logic              lst_we;
    logic [SEQ_W-1:0]  lst_addr;
    logic [31:0]       lst_wdata;
    logic              pb_we;
    logic [BYTE_W-1:0] pb_addr;
    logic [7:0]        pb_wdata;
    logic              rt_we;
    logic [RING_W-1:0] rt_addr;
    logic [31:0]       rt_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] lst;
    logic [7:0]  pb;
    logic [31:0] rt;
  } mem_rd_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [SEQ_W-1:0] popped;
    logic [TOT_W-1:0] pending;
    logic [31:0]      round;
    logic [31:0]      acc;
    logic [31:0]      stale;
  } result_t;

endpackage

// ===== sv/ntr_mem.sv =====
// ----------------------------------------------------------------------------
// ntr_mem
// Send-time table, pending bitmap and round-time ring, with registered reads.
// ----------------------------------------------------------------------------
module ntr_mem (
  input  logic              clk,
  input  ntr_pkg::mem_req_t req,
  output ntr_pkg::mem_rd_t  rd
);

  logic [31:0] lst_mem [ntr_pkg::MAX_SEQ];
  logic [7:0]  pb_mem  [ntr_pkg::NBYTES];
  logic [31:0] rt_mem  [ntr_pkg::RING];

  always_ff @(posedge clk) begin
    if (req.lst_we) begin
      lst_mem[req.lst_addr] <= req.lst_wdata;
    end
    if (req.pb_we) begin
      pb_mem[req.pb_addr] <= req.pb_wdata;
    end
    if (req.rt_we) begin
      rt_mem[req.rt_addr] <= req.rt_wdata;
    end
    rd.lst <= lst_mem[req.lst_addr];
    rd.pb  <= pb_mem[req.pb_addr];
    rd.rt  <= rt_mem[req.rt_addr];
  end

endmodule

// ===== sv/ntr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntr_ctrl
// Operation sequencer: clear sweep, record, fin, nack check, pop scan.
// ----------------------------------------------------------------------------
module ntr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     func,
  input  logic [31:0]                    seq_in,
  input  logic [31:0]                    tms_in,
  input  logic [31:0]                    fr_in,
  input  logic [ntr_pkg::TOT_W-1:0]      total,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ntr_pkg::result_t               res,
  output ntr_pkg::mem_req_t              mreq,
  input  ntr_pkg::mem_rd_t               mrd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_NACK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int unsigned BC_W = ntr_pkg::BYTE_W + 1;

  logic [2:0]                    state_r, state_nxt;
  logic [ntr_pkg::SEQ_W-1:0]     clr_r, clr_nxt;
  logic [31:0]                   seq_r, seq_nxt;
  logic [ntr_pkg::TOT_W-1:0]     pend_r, pend_nxt;
  logic [ntr_pkg::BYTE_W-1:0]    cur_r, cur_nxt;
  logic [31:0]                   rc_r, rc_nxt;
  logic [31:0]                   acc_r, acc_nxt;
  logic [31:0]                   stale_r, stale_nxt;
  logic [3:0]                    status_r, status_nxt;
  logic [ntr_pkg::SEQ_W-1:0]     pop_r, pop_nxt;
  logic [BC_W-1:0]               rem_r, rem_nxt;
  logic [3:0]                    dcnt_r, dcnt_nxt;
  logic [ntr_pkg::BYTE_W-1:0]    idx_r, idx_nxt;
  logic [BC_W-1:0]               step_r, step_nxt;

  logic [ntr_pkg::TOT_W-1:0]     eff;
  logic [BC_W-1:0]               nbytes;
  logic [31:0]                   rdiff;
  logic [BC_W-1:0]               rem_sh;
  logic [BC_W-1:0]               idx_inc;
  logic [7:0]                    mask;
  logic                          in_acc;

  function automatic logic [2:0] low_bit(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (b[i]) n = 3'(i);
    end
    return n;
  endfunction

  assign eff      = total[ntr_pkg::TOT_W-1] ? ntr_pkg::TOT_W'(ntr_pkg::MAX_SEQ) : total;
  assign nbytes   = BC_W'((eff + ntr_pkg::TOT_W'(7)) >> 3);
  assign rdiff    = rc_r - fr_in;
  assign rem_sh   = {rem_r[BC_W-2:0], cur_r[dcnt_r]};
  assign idx_inc  = {1'b0, idx_r} + BC_W'(1);
  assign mask     = 8'(1) << seq_r[2:0];
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    seq_nxt    = seq_r;
    pend_nxt   = pend_r;
    cur_nxt    = cur_r;
    rc_nxt     = rc_r;
    acc_nxt    = acc_r;
    stale_nxt  = stale_r;
    status_nxt = status_r;
    pop_nxt    = pop_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    mreq       = '0;
    unique case (state_r)
      S_CLR: begin
        mreq.lst_we   = 1'b1;
        mreq.lst_addr = clr_r;
        mreq.pb_we    = 1'b1;
        mreq.pb_addr  = clr_r[ntr_pkg::BYTE_W-1:0];
        mreq.rt_we    = 1'b1;
        mreq.rt_addr  = clr_r[ntr_pkg::RING_W-1:0];
        clr_nxt       = clr_r + ntr_pkg::SEQ_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          seq_nxt    = seq_in;
          pop_nxt    = '0;
          status_nxt = ntr_pkg::ST_DONE;
          state_nxt  = S_OUT;
          unique case (func)
            ntr_pkg::FN_RECORD: begin
              if (seq_in < {15'd0, eff}) begin
                mreq.lst_we    = 1'b1;
                mreq.lst_addr  = seq_in[ntr_pkg::SEQ_W-1:0];
                mreq.lst_wdata = tms_in;
              end else begin
                status_nxt = ntr_pkg::ST_RANGE;
              end
            end
            ntr_pkg::FN_FIN: begin
              rc_nxt        = rc_r + 32'd1;
              mreq.rt_we    = 1'b1;
              mreq.rt_addr  = rc_nxt[ntr_pkg::RING_W-1:0];
              mreq.rt_wdata = tms_in;
            end
            ntr_pkg::FN_NACK: begin
              if (fr_in > rc_r || rdiff >= 32'(ntr_pkg::RING)) begin
                status_nxt = ntr_pkg::ST_BADROUND;
              end else begin
                mreq.lst_addr = seq_in[ntr_pkg::SEQ_W-1:0];
                mreq.pb_addr  = seq_in[ntr_pkg::SEQ_W-1:3];
                mreq.rt_addr  = fr_in[ntr_pkg::RING_W-1:0];
                state_nxt     = S_NACK;
              end
            end
            ntr_pkg::FN_POP: begin
              if (pend_r == '0) begin
                status_nxt = ntr_pkg::ST_NONE;
              end else if (nbytes == '0) begin
                pend_nxt   = '0;
                status_nxt = ntr_pkg::ST_NONE;
              end else begin
                rem_nxt   = '0;
                dcnt_nxt  = 4'(ntr_pkg::BYTE_W - 1);
                state_nxt = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_NACK: begin
        state_nxt = S_OUT;
        priority if (seq_r >= {15'd0, eff}) begin
          status_nxt = ntr_pkg::ST_RANGE;
        end else if (mrd.lst == 32'd0) begin
          status_nxt = ntr_pkg::ST_NEVER;
        end else if ((mrd.pb & mask) != 8'd0) begin
          status_nxt = ntr_pkg::ST_PENDING;
        end else if (mrd.lst > mrd.rt) begin
          stale_nxt  = stale_r + 32'd1;
          status_nxt = ntr_pkg::ST_STALE;
        end else begin
          mreq.pb_we    = 1'b1;
          mreq.pb_addr  = seq_r[ntr_pkg::SEQ_W-1:3];
          mreq.pb_wdata = mrd.pb | mask;
          pend_nxt      = pend_r + ntr_pkg::TOT_W'(1);
          acc_nxt       = acc_r + 32'd1;
          status_nxt    = ntr_pkg::ST_ACCEPTED;
        end
      end
      S_DIV: begin
        rem_nxt  = (rem_sh >= nbytes) ? rem_sh - nbytes : rem_sh;
        dcnt_nxt = dcnt_r - 4'd1;
        if (dcnt_r == 4'd0) begin
          idx_nxt      = rem_nxt[ntr_pkg::BYTE_W-1:0];
          step_nxt     = '0;
          mreq.pb_addr = idx_nxt;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mrd.pb != 8'd0) begin
          pop_nxt       = {idx_r, low_bit(mrd.pb)};
          mreq.pb_we    = 1'b1;
          mreq.pb_addr  = idx_r;
          mreq.pb_wdata = mrd.pb & (mrd.pb - 8'd1);
          pend_nxt      = pend_r - ntr_pkg::TOT_W'(1);
          cur_nxt       = idx_r;
          status_nxt    = ntr_pkg::ST_POPPED;
          state_nxt     = S_OUT;
        end else begin
          step_nxt = step_r + BC_W'(1);
          if (step_nxt == nbytes) begin
            pend_nxt   = '0;
            status_nxt = ntr_pkg::ST_NONE;
            state_nxt  = S_OUT;
          end else begin
            idx_nxt      = (idx_inc == nbytes) ? '0 : idx_inc[ntr_pkg::BYTE_W-1:0];
            mreq.pb_addr = idx_nxt;
          end
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pend_r  <= '0;
      cur_r   <= '0;
      rc_r    <= '0;
      acc_r   <= '0;
      stale_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      cur_r   <= cur_nxt;
      rc_r    <= rc_nxt;
      acc_r   <= acc_nxt;
      stale_r <= stale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
  end

  assign res.status  = status_r;
  assign res.popped  = pop_r;
  assign res.pending = pend_r;
  assign res.round   = rc_r;
  assign res.acc     = acc_r;
  assign res.stale   = stale_r;

endmodule

// ===== sv/nack_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// nack_retransmit_tracker
// Send-time and pending-sequence tracker for a NACK-driven sender.
// ----------------------------------------------------------------------------
// Input beat: in_tuser carries the operation (record send, fin, nack, pop),
// in_tdata the sequence, time and feedback round. Each beat yields exactly
// one output beat: out_tuser carries the status, out_tdata the popped
// sequence and the running totals after the operation.
// Record, fin, a rejected round and a pop with nothing pending go straight
// to the output register; a nack reads the send-time table, bitmap and ring
// and decides in the next cycle. Any other pop first reduces the cursor
// modulo the bitmap size and then reads one bitmap byte per cycle until it
// finds a set bit or has scanned every byte. One item is in work at a time.
// After reset the block sweeps all 65536 table entries and holds in_tready
// low meanwhile; cfg writes are taken at any time.
// A stalled output holds its beat; the next input beat is still taken and
// its result waits inside until the output register frees up.
// ----------------------------------------------------------------------------
module nack_retransmit_tracker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // sequence_req, time_ms, feedback_round
  input  logic [1:0]    in_tuser,   // func
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // popped_sequence, pending_total,
                                    // current_round, accepted_count, stale_count
  output logic [3:0]    out_tuser,  // status
  input  logic          cfg_wr_en,
  input  logic [16:0]   cfg_wdata
);

  logic [ntr_pkg::TOT_W-1:0] total_r;
  logic                      out_valid_r;
  ntr_pkg::result_t          out_r;
  ntr_pkg::result_t          res;
  logic                      res_valid;
  logic                      res_ready;
  ntr_pkg::mem_req_t         mreq;
  ntr_pkg::mem_rd_t          mrd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= ntr_pkg::TOT_W'(ntr_pkg::MAX_SEQ);
    end else if (cfg_wr_en) begin
      total_r <= cfg_wdata;
    end
  end

  ntr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .func      (in_tuser),
    .seq_in    (in_tdata[31:0]),
    .tms_in    (in_tdata[63:32]),
    .fr_in     (in_tdata[95:64]),
    .total     (total_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .mrd       (mrd)
  );

  ntr_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rd  (mrd)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.stale, out_r.acc, out_r.round, out_r.pending, out_r.popped};

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during clear sweep");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ntr_pkg::ST_NONE)
    else $error("undefined status code");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ntr_pkg::ST_POPPED |-> out_tdata[15:0] == 16'd0)
    else $error("popped sequence set on non-pop result");

endmodule

// ===== verif/nack_retransmit_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nack_retransmit_tracker_tb
// Self-checking bench for the retransmission tracker. Drives record-send,
// fin, nack and pop beats and predicts every result with an internal copy
// of the send-time table, pending bitmap and fin-time ring. Walks the
// sequence total through several values, zero and the clipped maximum among
// them, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module nack_retransmit_tracker_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         cfg_wr_en;
  logic [16:0]  cfg_wdata;

  nack_retransmit_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wdata(cfg_wdata)
  );

  // tracker shadow state
  logic [31:0]               send_time [ntr_pkg::MAX_SEQ];
  logic [7:0]                pend_map  [ntr_pkg::NBYTES];
  logic [31:0]               fin_time  [ntr_pkg::RING];
  logic [ntr_pkg::TOT_W-1:0] seq_total;
  logic [ntr_pkg::TOT_W-1:0] pend_cnt;
  logic [ntr_pkg::BYTE_W-1:0] cursor;
  logic [31:0]               round_cnt;
  logic [31:0]               acc_cnt;
  logic [31:0]               stale_cnt;

  ntr_pkg::result_t expected_q[$];
  int      errors;
  bit      calm;
  bit      stall_req;
  logic [31:0] now_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned eff_total();
    return (seq_total > ntr_pkg::MAX_SEQ) ? ntr_pkg::MAX_SEQ : seq_total;
  endfunction

  function automatic ntr_pkg::result_t predict_beat(logic [1:0] fn, logic [31:0] seq,
                                                    logic [31:0] tms, logic [31:0] fr);
    ntr_pkg::result_t r;
    int unsigned nbytes, idx, b;
    logic [7:0] v;
    bit found;
    r = '0;
    r.status = ntr_pkg::ST_DONE;
    unique case (fn)
      ntr_pkg::FN_RECORD: begin
        if (seq < eff_total()) send_time[seq[ntr_pkg::SEQ_W-1:0]] = tms;
        else r.status = ntr_pkg::ST_RANGE;
      end
      ntr_pkg::FN_FIN: begin
        round_cnt = round_cnt + 32'd1;
        fin_time[round_cnt[ntr_pkg::RING_W-1:0]] = tms;
      end
      ntr_pkg::FN_NACK: begin
        if (fr > round_cnt || (round_cnt - fr) >= ntr_pkg::RING) begin
          r.status = ntr_pkg::ST_BADROUND;
        end else if (seq >= eff_total()) begin
          r.status = ntr_pkg::ST_RANGE;
        end else if (send_time[seq[ntr_pkg::SEQ_W-1:0]] == 0) begin
          r.status = ntr_pkg::ST_NEVER;
        end else if (pend_map[seq[ntr_pkg::SEQ_W-1:3]][seq[2:0]]) begin
          r.status = ntr_pkg::ST_PENDING;
        end else if (send_time[seq[ntr_pkg::SEQ_W-1:0]] >
                     fin_time[fr[ntr_pkg::RING_W-1:0]]) begin
          stale_cnt = stale_cnt + 32'd1;
          r.status = ntr_pkg::ST_STALE;
        end else begin
          pend_map[seq[ntr_pkg::SEQ_W-1:3]][seq[2:0]] = 1'b1;
          pend_cnt = pend_cnt + ntr_pkg::TOT_W'(1);
          acc_cnt = acc_cnt + 32'd1;
          r.status = ntr_pkg::ST_ACCEPTED;
        end
      end
      default: begin
        if (pend_cnt == 0) r.status = ntr_pkg::ST_NONE;
        else begin
          nbytes = (eff_total() + 7) / 8;
          found = 1'b0;
          for (int unsigned s = 0; s < nbytes && !found; s++) begin
            idx = (cursor + s) % nbytes;
            v = pend_map[idx];
            if (v != 0) begin
              b = 0;
              while (b < 7 && !v[b]) b++;
              r.popped = ntr_pkg::SEQ_W'(idx * 8 + b);
              pend_map[idx] = v & (v - 8'd1);
              pend_cnt = pend_cnt - ntr_pkg::TOT_W'(1);
              cursor = ntr_pkg::BYTE_W'(idx);
              r.status = ntr_pkg::ST_POPPED;
              found = 1'b1;
            end
          end
          if (!found) begin
            pend_cnt = '0;
            r.status = ntr_pkg::ST_NONE;
          end
        end
      end
    endcase
    r.pending = pend_cnt;
    r.round   = round_cnt;
    r.acc     = acc_cnt;
    r.stale   = stale_cnt;
    return r;
  endfunction

  task automatic send_beat(logic [1:0] fn, logic [31:0] seq, logic [31:0] tms,
                           logic [31:0] fr);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {fr, tms, seq};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_beat(fn, seq, tms, fr));
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic write_total(logic [16:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seq_total = v;
  endtask

  // mostly well-formed traffic near the current total, some raw noise
  task automatic random_beat();
    logic [1:0]  fn;
    logic [31:0] seq, tms, fr;
    int unsigned w, span;
    if ($urandom_range(0, 9) == 0) begin
      send_beat(2'($urandom), $urandom, $urandom, $urandom);
      return;
    end
    w = $urandom_range(0, 99);
    fn = (w < 30) ? ntr_pkg::FN_RECORD : (w < 40) ? ntr_pkg::FN_FIN :
         (w < 80) ? ntr_pkg::FN_NACK : ntr_pkg::FN_POP;
    seq = $urandom_range(0, (eff_total() > 300) ? 300 : eff_total() + 2);
    if ($urandom_range(0, 15) == 0) seq = eff_total() - 1 + $urandom_range(0, 2);
    now_ms = now_ms + $urandom_range(0, 3);
    tms = now_ms;
    if ($urandom_range(0, 30) == 0) tms = 0;
    if ($urandom_range(0, 30) == 0) tms = $urandom;
    span = (round_cnt > 70) ? 70 : round_cnt;
    fr = round_cnt - $urandom_range(0, span);
    if ($urandom_range(0, 20) == 0) fr = round_cnt + 32'd1;
    send_beat(fn, seq, tms, fr);
  endtask

  task automatic test_directed();
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    send_beat(ntr_pkg::FN_NACK, 5, 0, 0);
    send_beat(ntr_pkg::FN_RECORD, 5, 10, 0);
    send_beat(ntr_pkg::FN_NACK, 5, 0, 0);
    send_beat(ntr_pkg::FN_FIN, 0, 20, 0);
    send_beat(ntr_pkg::FN_NACK, 5, 0, 1);
    send_beat(ntr_pkg::FN_NACK, 5, 0, 1);
    send_beat(ntr_pkg::FN_NACK, 5, 0, 2);
    send_beat(ntr_pkg::FN_RECORD, 7, 30, 0);
    send_beat(ntr_pkg::FN_NACK, 7, 0, 1);
    send_beat(ntr_pkg::FN_RECORD, 65535, 32'hFFFF_FFFF, 0);
    send_beat(ntr_pkg::FN_RECORD, 65536, 1, 0);
    send_beat(ntr_pkg::FN_RECORD, 32'hFFFF_FFFF, 1, 0);
    send_beat(ntr_pkg::FN_FIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ntr_pkg::FN_NACK, 65535, 0, 2);
    send_beat(ntr_pkg::FN_NACK, 65535, 0, 32'hFFFF_FFFF);
    send_beat(ntr_pkg::FN_RECORD, 9, 0, 0);
    send_beat(ntr_pkg::FN_NACK, 9, 0, 2);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    now_ms = 100;
  endtask

  task automatic test_round_wrap();
    for (int i = 0; i < 70; i++) send_beat(ntr_pkg::FN_FIN, 0, now_ms + i, 0);
    now_ms = now_ms + 70;
    send_beat(ntr_pkg::FN_NACK, 5, 0, round_cnt - ntr_pkg::RING);
    send_beat(ntr_pkg::FN_NACK, 5, 0, round_cnt - ntr_pkg::RING + 1);
  endtask

  task automatic test_total_edges();
    write_total(17'd0);
    send_beat(ntr_pkg::FN_RECORD, 0, 5, 0);
    send_beat(ntr_pkg::FN_NACK, 0, 0, round_cnt);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    write_total(17'd64);
    for (int i = 40; i < 64; i += 3) begin
      send_beat(ntr_pkg::FN_RECORD, i, 1, 0);
      send_beat(ntr_pkg::FN_NACK, i, 0, round_cnt);
    end
    write_total(17'd8);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
    write_total(17'd1);
    send_beat(ntr_pkg::FN_RECORD, 0, 1, 0);
    send_beat(ntr_pkg::FN_RECORD, 1, 1, 0);
    send_beat(ntr_pkg::FN_NACK, 0, 0, round_cnt);
    send_beat(ntr_pkg::FN_POP, 0, 0, 0);
  endtask

  task automatic test_random(logic [16:0] total, int n);
    write_total(total);
    for (int i = 0; i < n; i++) random_beat();
  endtask

  task automatic test_backpressure();
    stall_req = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 30; i++) random_beat();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    ntr_pkg::result_t exp_r, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tuser;
      got.popped  = out_tdata[15:0];
      got.pending = out_tdata[32:16];
      got.round   = out_tdata[64:33];
      got.acc     = out_tdata[96:65];
      got.stale   = out_tdata[128:97];
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.popped != exp_r.popped) begin
          $error("popped_sequence exp %0d got %0d", exp_r.popped, got.popped); errors++;
        end
        if (got.pending != exp_r.pending) begin
          $error("pending_total exp %0d got %0d", exp_r.pending, got.pending); errors++;
        end
        if (got.round != exp_r.round) begin
          $error("current_round exp %0d got %0d", exp_r.round, got.round); errors++;
        end
        if (got.acc != exp_r.acc) begin
          $error("accepted_count exp %0d got %0d", exp_r.acc, got.acc); errors++;
        end
        if (got.stale != exp_r.stale) begin
          $error("stale_count exp %0d got %0d", exp_r.stale, got.stale); errors++;
        end
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    now_ms = 1;
    seq_total = 17'd65536;
    pend_cnt = '0;
    cursor = '0;
    round_cnt = '0;
    acc_cnt = '0;
    stale_cnt = '0;
    foreach (send_time[i]) send_time[i] = '0;
    foreach (pend_map[i]) pend_map[i] = '0;
    foreach (fin_time[i]) fin_time[i] = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ntr_pkg::FN_RECORD;
    cfg_wr_en <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_round_wrap();
    test_total_edges();
    test_random(17'd16, 200);
    test_random(17'd200, 300);
    test_backpressure();
    test_random(17'd9, 150);
    test_random(17'h1FFFF, 80);
    test_random(17'd65536, 60);
    test_random(17'd1024, 200);
    calm = 1'b1;
    test_random(17'd64, 200);

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
sv/ntr_pkg.sv
sv/ntr_mem.sv
sv/ntr_ctrl.sv
sv/nack_retransmit_tracker.sv
verif/nack_retransmit_tracker_tb.sv
